### design/sam_pkg.sv
package sam_pkg;

	// Station storage and counter sizing.
	localparam int STATIONS   = 2;
	localparam int ST_W       = 1;
	localparam int COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration port and register widths.
	localparam int CFG_W      = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int PERSIST_W  = 16;
	localparam logic [PERSIST_W-1:0] PERSIST_RESET = 16'd10;

	// Sample magnitude and the width of the scaled limits that are compared against it.
	localparam int MAG_W  = 31;
	localparam int LIM_W  = 40;

	// Division by 100 of a 31-bit register value through a reciprocal multiply.
	localparam int QUOT_W      = 25;
	localparam int PROD_W      = 62;
	localparam logic [CFG_W-1:0] RECIP100 = 31'h51EB851F;
	localparam int RECIP_SHIFT = 37;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRAIN_SET   = 3'd0,
		REG_DRAIN_UPPER = 3'd1,
		REG_GATE_SET    = 3'd2,
		REG_GATE_UPPER  = 3'd3,
		REG_DCUR_UPPER  = 3'd4,
		REG_GCUR_UPPER  = 3'd5,
		REG_TEMP_UPPER  = 3'd6,
		REG_PERSIST     = 3'd7
	} cfg_reg_t;

	// Persistence counters kept for each station.
	typedef enum logic [2:0] {
		CHK_DOVER  = 3'd0,
		CHK_DUNDER = 3'd1,
		CHK_GOVER  = 3'd2,
		CHK_GUNDER = 3'd3,
		CHK_DCUR   = 3'd4,
		CHK_GCUR   = 3'd5,
		CHK_TEMP   = 3'd6
	} chk_t;
	localparam int NUM_CHK = 7;

	// Voltage alarm codes.
	localparam logic [1:0] ALARM_NORMAL = 2'd0;
	localparam logic [1:0] ALARM_OVER   = 2'd1;
	localparam logic [1:0] ALARM_UNDER  = 2'd2;

	// Bit positions of the other alarm flags.
	localparam int FLAG_DCUR = 0;
	localparam int FLAG_GCUR = 1;
	localparam int FLAG_TEMP = 2;

	typedef struct packed {
		logic        station;
		logic        running;
		logic [31:0] drain_volt;
		logic [31:0] gate_volt;
		logic [31:0] drain_curr;
		logic [31:0] gate_curr;
		logic [31:0] temperature;
	} sample_t;

	typedef struct packed {
		logic       station_out;
		logic [1:0] drain_alarm;
		logic [1:0] gate_alarm;
		logic       drain_curr_alarm;
		logic       gate_curr_alarm;
		logic       temp_alarm;
		logic       error_stop;
	} result_t;

	// Next value of a persistence counter: count up to saturation or clear.
	function automatic logic [COUNT_BITS-1:0] persist_next(
		input logic [COUNT_BITS-1:0] cnt,
		input logic                  viol
	);
		logic [COUNT_BITS-1:0] nxt;
		if (!viol) begin
			nxt = '0;
		end else if (cnt == CNT_MAX) begin
			nxt = cnt;
		end else begin
			nxt = cnt + COUNT_BITS'(1);
		end
		return nxt;
	endfunction

endpackage

### design/station_alarm_monitor_core.sv
// Path: a sample is held in the input register, then its result in the result register.
// Throughput: one sample per cycle unless stalled; all limit compares, counter updates and
// alarm latching for the addressed station happen in the single stage after the input register.
// Reset: arst_n clears all counters, latched alarms, run flags and the valid flags at once;
// limit registers reset to zero and the persistence count to ten.
module station_alarm_monitor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  sam_pkg::sample_t                sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output sam_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [sam_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sam_pkg::CFG_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [sam_pkg::CFG_W-1:0]     drain_set_q;
	logic [sam_pkg::CFG_W-1:0]     drain_upper_q;
	logic [sam_pkg::CFG_W-1:0]     gate_upper_q;
	logic [sam_pkg::CFG_W-1:0]     temp_upper_q;
	logic                          gate_on_q;
	logic [sam_pkg::QUOT_W-1:0]    gate_div_q;
	logic [sam_pkg::QUOT_W-1:0]    dcur_div_q;
	logic [sam_pkg::QUOT_W-1:0]    gcur_div_q;
	logic [sam_pkg::PERSIST_W-1:0] persist_q;

	logic [sam_pkg::PROD_W-1:0]    cfg_prod;
	logic [sam_pkg::QUOT_W-1:0]    cfg_quot;

	// Input stage and result register.
	logic                          valid_s1;
	sam_pkg::sample_t              sample_s1;
	logic                          result_valid_q;
	sam_pkg::result_t              result_q;
	logic                          move_s1;

	// Per-station state.
	logic [sam_pkg::COUNT_BITS-1:0] cnt_q [sam_pkg::STATIONS][sam_pkg::NUM_CHK];
	logic [1:0]                     dcode_q [sam_pkg::STATIONS];
	logic [1:0]                     gcode_q [sam_pkg::STATIONS];
	logic [2:0]                     oth_q [sam_pkg::STATIONS];
	logic [sam_pkg::STATIONS-1:0]   run_q;

	// Update of the addressed station.
	logic [sam_pkg::MAG_W-1:0]      mag_dv, mag_gv, mag_dc, mag_gc, mag_tc;
	logic [sam_pkg::NUM_CHK-1:0]    viol;
	logic [sam_pkg::NUM_CHK-1:0]    latch;
	logic [sam_pkg::COUNT_BITS-1:0] cnt_nxt [sam_pkg::NUM_CHK];
	logic [1:0]                     dcode_nxt, gcode_nxt;
	logic [2:0]                     oth_nxt;
	logic                           error_nxt;

	// The quotient by 100 of the write data serves the gate and both current limits.
	assign cfg_prod = sam_pkg::PROD_W'(cfg_data) * sam_pkg::PROD_W'(sam_pkg::RECIP100);
	assign cfg_quot = sam_pkg::QUOT_W'(cfg_prod >> sam_pkg::RECIP_SHIFT);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_set_q   <= '0;
			drain_upper_q <= '0;
			gate_upper_q  <= '0;
			temp_upper_q  <= '0;
			gate_on_q     <= 1'b0;
			gate_div_q    <= '0;
			dcur_div_q    <= '0;
			gcur_div_q    <= '0;
			persist_q     <= sam_pkg::PERSIST_RESET;
		end else if (cfg_we) begin
			unique case (sam_pkg::cfg_reg_t'(cfg_index))
				sam_pkg::REG_DRAIN_SET: begin
					drain_set_q <= cfg_data;
				end
				sam_pkg::REG_DRAIN_UPPER: begin
					drain_upper_q <= cfg_data;
				end
				sam_pkg::REG_GATE_SET: begin
					gate_on_q  <= (cfg_data != '0);
					gate_div_q <= cfg_quot;
				end
				sam_pkg::REG_GATE_UPPER: begin
					gate_upper_q <= cfg_data;
				end
				sam_pkg::REG_DCUR_UPPER: begin
					dcur_div_q <= cfg_quot;
				end
				sam_pkg::REG_GCUR_UPPER: begin
					gcur_div_q <= cfg_quot;
				end
				sam_pkg::REG_TEMP_UPPER: begin
					temp_upper_q <= cfg_data;
				end
				sam_pkg::REG_PERSIST: begin
					persist_q <= cfg_data[sam_pkg::PERSIST_W-1:0];
				end
			endcase
		end
	end

	// Handshake: the input stage advances whenever the result register is free.
	assign move_s1      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !move_s1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// Magnitudes with the sign bit dropped.
	assign mag_dv = sample_s1.drain_volt[sam_pkg::MAG_W-1:0];
	assign mag_gv = sample_s1.gate_volt[sam_pkg::MAG_W-1:0];
	assign mag_dc = sample_s1.drain_curr[sam_pkg::MAG_W-1:0];
	assign mag_gc = sample_s1.gate_curr[sam_pkg::MAG_W-1:0];
	assign mag_tc = sample_s1.temperature[sam_pkg::MAG_W-1:0];

	// Limit checks. Each test on a sample divided by ten is rewritten as an exact
	// test on the raw magnitude against a scaled limit; temperature is compared directly.
	always_comb begin
		viol = '0;
		viol[sam_pkg::CHK_DOVER] = sam_pkg::LIM_W'(mag_dv) >=
			sam_pkg::LIM_W'(drain_upper_q) * sam_pkg::LIM_W'(100) + sam_pkg::LIM_W'(10);
		if (sam_pkg::LIM_W'(mag_dv) < sam_pkg::LIM_W'(200000)) begin
			viol[sam_pkg::CHK_DUNDER] = sam_pkg::LIM_W'(mag_dv) <
				sam_pkg::LIM_W'(drain_set_q) * sam_pkg::LIM_W'(80);
		end else begin
			viol[sam_pkg::CHK_DUNDER] = sam_pkg::LIM_W'(mag_dv) + sam_pkg::LIM_W'(50000) <
				sam_pkg::LIM_W'(drain_set_q) * sam_pkg::LIM_W'(100);
		end
		viol[sam_pkg::CHK_GOVER] = sam_pkg::LIM_W'(mag_gv) >=
			sam_pkg::LIM_W'(gate_upper_q) * sam_pkg::LIM_W'(100) + sam_pkg::LIM_W'(10);
		viol[sam_pkg::CHK_GUNDER] = sam_pkg::LIM_W'(mag_gv) <
			sam_pkg::LIM_W'(gate_div_q) * sam_pkg::LIM_W'(8000);
		viol[sam_pkg::CHK_DCUR] = sam_pkg::LIM_W'(mag_dc) >=
			sam_pkg::LIM_W'(dcur_div_q) * sam_pkg::LIM_W'(10) + sam_pkg::LIM_W'(10);
		viol[sam_pkg::CHK_GCUR] = sam_pkg::LIM_W'(mag_gc) >=
			sam_pkg::LIM_W'(gcur_div_q) * sam_pkg::LIM_W'(10) + sam_pkg::LIM_W'(10);
		viol[sam_pkg::CHK_TEMP] = mag_tc > temp_upper_q;
	end

	// Counter update, alarm latching and error stop for the addressed station.
	always_comb begin
		for (int c = 0; c < sam_pkg::NUM_CHK; c++) begin
			cnt_nxt[c] = sam_pkg::persist_next(cnt_q[sample_s1.station][c], viol[c]);
			latch[c]   = viol[c] && (32'(cnt_nxt[c]) >= 32'(persist_q));
		end

		// A zero setpoint leaves that voltage's counters and code untouched.
		if (drain_set_q == '0) begin
			cnt_nxt[sam_pkg::CHK_DOVER]  = cnt_q[sample_s1.station][sam_pkg::CHK_DOVER];
			cnt_nxt[sam_pkg::CHK_DUNDER] = cnt_q[sample_s1.station][sam_pkg::CHK_DUNDER];
			latch[sam_pkg::CHK_DOVER]    = 1'b0;
			latch[sam_pkg::CHK_DUNDER]   = 1'b0;
		end
		if (!gate_on_q) begin
			cnt_nxt[sam_pkg::CHK_GOVER]  = cnt_q[sample_s1.station][sam_pkg::CHK_GOVER];
			cnt_nxt[sam_pkg::CHK_GUNDER] = cnt_q[sample_s1.station][sam_pkg::CHK_GUNDER];
			latch[sam_pkg::CHK_GOVER]    = 1'b0;
			latch[sam_pkg::CHK_GUNDER]   = 1'b0;
		end

		// Over is applied before under, so under wins when both latch.
		dcode_nxt = dcode_q[sample_s1.station];
		if (latch[sam_pkg::CHK_DOVER]) begin
			dcode_nxt = sam_pkg::ALARM_OVER;
		end
		if (latch[sam_pkg::CHK_DUNDER]) begin
			dcode_nxt = sam_pkg::ALARM_UNDER;
		end
		gcode_nxt = gcode_q[sample_s1.station];
		if (latch[sam_pkg::CHK_GOVER]) begin
			gcode_nxt = sam_pkg::ALARM_OVER;
		end
		if (latch[sam_pkg::CHK_GUNDER]) begin
			gcode_nxt = sam_pkg::ALARM_UNDER;
		end

		oth_nxt = oth_q[sample_s1.station];
		oth_nxt[sam_pkg::FLAG_DCUR] = oth_nxt[sam_pkg::FLAG_DCUR] | latch[sam_pkg::CHK_DCUR];
		oth_nxt[sam_pkg::FLAG_GCUR] = oth_nxt[sam_pkg::FLAG_GCUR] | latch[sam_pkg::CHK_GCUR];
		oth_nxt[sam_pkg::FLAG_TEMP] = oth_nxt[sam_pkg::FLAG_TEMP] | latch[sam_pkg::CHK_TEMP];

		// Error stop looks at every station's state as it stands after this sample.
		error_nxt = 1'b0;
		for (int s = 0; s < sam_pkg::STATIONS; s++) begin
			if (sam_pkg::ST_W'(s) == sample_s1.station) begin
				error_nxt = error_nxt | (sample_s1.running &&
					(dcode_nxt != '0 || gcode_nxt != '0 || oth_nxt != '0));
			end else begin
				error_nxt = error_nxt | (run_q[s] &&
					(dcode_q[s] != '0 || gcode_q[s] != '0 || oth_q[s] != '0));
			end
		end
	end

	// Station state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < sam_pkg::STATIONS; s++) begin
				for (int c = 0; c < sam_pkg::NUM_CHK; c++) begin
					cnt_q[s][c] <= '0;
				end
				dcode_q[s] <= sam_pkg::ALARM_NORMAL;
				gcode_q[s] <= sam_pkg::ALARM_NORMAL;
				oth_q[s]   <= '0;
			end
			run_q <= '0;
		end else if (move_s1) begin
			for (int c = 0; c < sam_pkg::NUM_CHK; c++) begin
				cnt_q[sample_s1.station][c] <= cnt_nxt[c];
			end
			dcode_q[sample_s1.station] <= dcode_nxt;
			gcode_q[sample_s1.station] <= gcode_nxt;
			oth_q[sample_s1.station]   <= oth_nxt;
			run_q[sample_s1.station]   <= sample_s1.running;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_q.station_out      <= sample_s1.station;
			result_q.drain_alarm      <= dcode_nxt;
			result_q.gate_alarm       <= gcode_nxt;
			result_q.drain_curr_alarm <= oth_nxt[sam_pkg::FLAG_DCUR];
			result_q.gate_curr_alarm  <= oth_nxt[sam_pkg::FLAG_GCUR];
			result_q.temp_alarm       <= oth_nxt[sam_pkg::FLAG_TEMP];
			result_q.error_stop       <= error_nxt;
		end
	end

	// Latched alarms only clear at reset.
	for (genvar g = 0; g < sam_pkg::STATIONS; g++) begin : g_sticky
		a_oth_sticky: assert property (@(posedge clk) disable iff (!arst_n)
			((oth_q[g] & $past(oth_q[g])) == $past(oth_q[g])))
			else $error("other alarm flag cleared without reset");
		a_dcode_sticky: assert property (@(posedge clk) disable iff (!arst_n)
			($past(dcode_q[g]) != sam_pkg::ALARM_NORMAL) |-> (dcode_q[g] != sam_pkg::ALARM_NORMAL))
			else $error("drain alarm code returned to normal without reset");
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("input stalled while the result side is free");

	a_error_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.error_stop) |-> (run_q != '0))
		else $error("error stop shown with no station running");

endmodule
